>>> design/point_cloud_to_scan_binner_core_defines.svh
// assertion macros shared by the scan binner rtl
`ifndef POINT_CLOUD_TO_SCAN_BINNER_CORE_DEFINES_SVH
`define POINT_CLOUD_TO_SCAN_BINNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PCSB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCSB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCSB_ASSERT_IMP(lbl, ante, cons, msg)
`define PCSB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/pcsb_pkg.sv
// types, constants and the arctangent table of the scan binner
package pcsb_pkg;

    localparam int MAX_BINS_DEF = 512;
    localparam int CORDIC_STEPS = 40;
    localparam int SQRT_STEPS   = 16;
    localparam int DIV_STEPS    = 20;
    localparam int XW           = 49;
    localparam int ZW           = 60;
    localparam int APB_AW       = 5;

    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;
    localparam logic [15:0] EMPTY_SAT  = 16'hFFFE;

    localparam logic signed [15:0] HEIGHT_LOW_RST  = 16'sd0;
    localparam logic signed [15:0] HEIGHT_HIGH_RST = 16'sd1000;
    localparam logic [15:0]        RANGE_FLOOR_RST = 16'd450;
    localparam logic [15:0]        RANGE_CEIL_RST  = 16'd4000;
    localparam logic signed [18:0] ANGLE_START_RST = -19'sd102944;
    localparam logic signed [18:0] ANGLE_END_RST   = 19'sd102944;
    localparam logic [17:0]        ANGLE_STEP_RST  = 18'd572;

    typedef enum logic [2:0] {
        REG_HEIGHT_LOW  = 3'd0,
        REG_HEIGHT_HIGH = 3'd1,
        REG_RANGE_FLOOR = 3'd2,
        REG_RANGE_CEIL  = 3'd3,
        REG_ANGLE_START = 3'd4,
        REG_ANGLE_END   = 3'd5,
        REG_ANGLE_STEP  = 3'd6,
        REG_EMPTY_INF   = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_INVALID  = 3'd1,
        ST_HEIGHT   = 3'd2,
        ST_NEAR     = 3'd3,
        ST_ANGLE    = 3'd4,
        ST_FARTHER  = 3'd5,
        ST_BEYOND   = 3'd6
    } t_status;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic signed [ZW-1:0] t_atan_tab [CORDIC_STEPS];

    // unsigned quotient by shift and subtract, elaboration only
    function automatic longint unsigned udiv(longint unsigned a, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in q56 by its power series, elaboration only
    function automatic longint atan_inv(longint unsigned n);
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        term = udiv(64'd1 << 56, n);
        sum  = 0;
        for (int k = 0; k < 64; k++) begin
            if (term != 0) begin
                q = udiv(term, longint'(2 * k + 1));
                if (k[0]) sum = sum - longint'(q);
                else      sum = sum + longint'(q);
                term = udiv(udiv(term, n), n);
            end
        end
        return sum;
    endfunction

    function automatic t_atan_tab build_atan();
        t_atan_tab t;
        t[0] = ZW'(4 * atan_inv(64'd5) - atan_inv(64'd239));
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            t[i] = ZW'(atan_inv(64'd1 << i));
        end
        return t;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan();

endpackage

>>> design/pcsb_in_if.sv
// input channel of the scan binner: one point or one bin read per beat
interface pcsb_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               point_valid;
    logic [8:0]         read_bin;

    modport source (output valid, operation, pos_x, pos_y, pos_z, point_valid, read_bin,
                    input ready);
    modport sink (input valid, operation, pos_x, pos_y, pos_z, point_valid, read_bin,
                  output ready);
endinterface

>>> design/pcsb_out_if.sv
// result channel of the scan binner: one result per beat
interface pcsb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [8:0]  bin_index;
    logic [15:0] bin_range;
    logic        bin_empty;
    logic [9:0]  bin_total;

    modport source (output valid, status, bin_index, bin_range, bin_empty, bin_total,
                    input ready);
    modport sink (input valid, status, bin_index, bin_range, bin_empty, bin_total,
                  output ready);
endinterface

>>> design/pcsb_ram.sv
// generic simple dual-port ram with registered read
module pcsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> design/point_cloud_to_scan_binner_core.sv
// top level of the scan binner: sequencer, arithmetic units and bin memory
//
// points arrive on i_pt (valid/ready); an add beat bins a point by planar range
// and angle, a read beat returns one bin and empties it. each input beat gives
// exactly one beat on o_res. the user is to write registers over the apb port
// only while idle; the block itself does not enforce this. one item is in
// flight at a time. a 20-step restoring divider works out the bin count for
// every item, x and y are squared in turn on one multiplier, a 16-step square
// root gives the range, a 40-step cordic the angle, and the divider again the
// bin index. each bin access is one read of the single bin memory, then a
// write (for an add only if the new range is nearer). rejected adds end early.
// after reset a clearing pass writes every bin empty, one per cycle; i_pt.ready
// stays low meanwhile, register writes are taken. the result sits in an output
// register; when the receiver stalls it holds there, the next item may be
// taken and is computed, and its result waits for the register to free up.
module point_cloud_to_scan_binner_core
    import pcsb_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    pcsb_in_if.sink            i_pt,
    pcsb_out_if.source         o_res
);
    `include "point_cloud_to_scan_binner_core_defines.svh"

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CNT  = 13'b0000000000010,
        S_DISP = 13'b0000000000100,
        S_SQ   = 13'b0000000001000,
        S_SQRT = 13'b0000000010000,
        S_CHK  = 13'b0000000100000,
        S_CORD = 13'b0000001000000,
        S_WIN  = 13'b0000010000000,
        S_IDX  = 13'b0000100000000,
        S_BIN  = 13'b0001000000000,
        S_MRD  = 13'b0010000000000,
        S_WB   = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_iter;

    // configuration registers
    logic signed [15:0] r_h_lo, r_h_hi;
    logic [15:0]        r_r_floor, r_r_ceil;
    logic signed [18:0] r_a_start, r_a_end;
    logic [17:0]        r_a_step;
    logic               r_inf;

    // item being worked on
    logic               r_op, r_pv;
    logic signed [15:0] r_px, r_py, r_pz;
    logic [8:0]         r_rb;

    // pending result
    t_status     r_st;
    logic [8:0]  r_bidx;
    logic [15:0] r_brng;
    logic        r_bemp;

    // output register
    logic        r_ov;
    t_status     r_o_st;
    logic [8:0]  r_o_idx;
    logic [15:0] r_o_rng;
    logic        r_o_emp;
    logic [9:0]  r_o_tot;

    // arithmetic state
    logic [19:0]          r_div_quo;
    logic [17:0]          r_div_rem;
    logic                 r_wpos;
    logic [CW-1:0]        r_count;
    logic [31:0]          r_sq_val, r_sq_root, r_sq_bit;
    logic [15:0]          r_range;
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic [AW-1:0]        r_addr;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_cnt;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata, mem_rdata;

    logic in_take, out_free;
    assign in_take  = i_pt.valid && i_pt.ready;
    assign out_free = !r_ov || o_res.ready;

    assign i_pt.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign pready     = 1'b1;

    // apb register file
    logic     cfg_we;
    t_reg_idx cfg_idx;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_lo    <= HEIGHT_LOW_RST;
            r_h_hi    <= HEIGHT_HIGH_RST;
            r_r_floor <= RANGE_FLOOR_RST;
            r_r_ceil  <= RANGE_CEIL_RST;
            r_a_start <= ANGLE_START_RST;
            r_a_end   <= ANGLE_END_RST;
            r_a_step  <= ANGLE_STEP_RST;
            r_inf     <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_HEIGHT_LOW:  r_h_lo    <= pwdata[15:0];
                REG_HEIGHT_HIGH: r_h_hi    <= pwdata[15:0];
                REG_RANGE_FLOOR: r_r_floor <= pwdata[15:0];
                REG_RANGE_CEIL:  r_r_ceil  <= pwdata[15:0];
                REG_ANGLE_START: r_a_start <= pwdata[18:0];
                REG_ANGLE_END:   r_a_end   <= pwdata[18:0];
                REG_ANGLE_STEP:  r_a_step  <= pwdata[17:0];
                REG_EMPTY_INF:   r_inf     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HEIGHT_LOW:  prdata = {16'd0, r_h_lo};
            REG_HEIGHT_HIGH: prdata = {16'd0, r_h_hi};
            REG_RANGE_FLOOR: prdata = {16'd0, r_r_floor};
            REG_RANGE_CEIL:  prdata = {16'd0, r_r_ceil};
            REG_ANGLE_START: prdata = {13'd0, r_a_start};
            REG_ANGLE_END:   prdata = {13'd0, r_a_end};
            REG_ANGLE_STEP:  prdata = {14'd0, r_a_step};
            REG_EMPTY_INF:   prdata = {31'd0, r_inf};
            default:         prdata = 32'd0;
        endcase
    end

    // zero step counts as one
    logic [17:0] step_eff;
    assign step_eff = (r_a_step == 18'd0) ? 18'd1 : r_a_step;

    // window width and rounded-up count dividend
    logic signed [19:0] win_w;
    logic [19:0]        cnt_dvd;
    assign win_w   = 20'(r_a_end) - 20'(r_a_start);
    assign cnt_dvd = 20'(win_w) + 20'(step_eff) - 20'd1;

    // shared restoring divider step
    logic [18:0] div_sh;
    logic        div_ge;
    logic [17:0] div_rem_nx;
    assign div_sh     = {r_div_rem, r_div_quo[19]};
    assign div_ge     = div_sh >= {1'b0, step_eff};
    assign div_rem_nx = div_ge ? 18'(div_sh - {1'b0, step_eff}) : div_sh[17:0];

    // bin count, saturated
    logic [CW-1:0] cnt_val;
    always_comb begin
        if (!r_wpos) begin
            cnt_val = '0;
        end else if (r_div_quo > 20'(MAX_BINS)) begin
            cnt_val = CW'(MAX_BINS);
        end else begin
            cnt_val = CW'(r_div_quo);
        end
    end

    logic rb_in;
    assign rb_in = 20'(r_rb) < 20'(cnt_val);

    // square of x then y on one multiplier
    logic signed [15:0] mul_a;
    logic signed [31:0] mul_p;
    assign mul_a = (r_iter == 6'd0) ? r_px : r_py;
    assign mul_p = mul_a * mul_a;

    // square root digit step
    logic [31:0] sq_sum;
    logic        sq_ge;
    assign sq_sum = r_sq_root + r_sq_bit;
    assign sq_ge  = r_sq_val >= sq_sum;

    // rejection tests
    logic rej_ht, rej_near, at_origin;
    assign rej_ht    = (r_pz > r_h_hi) || (r_pz < r_h_lo);
    assign rej_near  = r_range < r_r_floor;
    assign at_origin = (r_px == 16'sd0) && (r_py == 16'sd0);

    // cordic step
    logic signed [XW-1:0] cx_sh, cy_sh;
    logic signed [ZW-1:0] atan_i;
    logic                 c_pos;
    assign cx_sh  = r_cx >>> r_iter;
    assign cy_sh  = r_cy >>> r_iter;
    assign atan_i = ATAN_TAB[r_iter];
    assign c_pos  = r_cy > 0;

    // rounded angle and offset into the window
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64'd1 << 39);
    logic signed [ZW-1:0] z_rnd;
    logic signed [19:0]   ang, ang_ofs;
    logic                 rej_ang;
    assign z_rnd   = r_cz + ROUND_HALF;
    assign ang     = z_rnd[ZW-1:40];
    assign rej_ang = (ang < 20'(r_a_start)) || (ang > 20'(r_a_end));
    assign ang_ofs = ang - 20'(r_a_start);

    // bin index with the last-bin clamp
    logic [19:0] idx_adj;
    logic        idx_in;
    always_comb begin
        if ((r_div_quo == 20'(r_count)) && (r_count != '0)) begin
            idx_adj = 20'(r_count) - 20'd1;
        end else begin
            idx_adj = r_div_quo;
        end
    end
    assign idx_in = idx_adj < 20'(r_count);

    // empty bin encoding
    logic [16:0] fill_sum;
    logic [15:0] fill_val;
    assign fill_sum = {1'b0, r_r_ceil} + 17'd1000;
    assign fill_val = r_inf ? EMPTY_MARK :
                      (fill_sum > {1'b0, EMPTY_SAT}) ? EMPTY_SAT : fill_sum[15:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_take) n_state = S_CNT;
            S_CNT:  if (r_iter == 6'(DIV_STEPS - 1)) n_state = S_DISP;
            S_DISP: begin
                if (r_op == OP_READ) n_state = rb_in ? S_MRD : S_OUT;
                else                 n_state = S_SQ;
            end
            S_SQ:   if (r_iter == 6'd1) n_state = S_SQRT;
            S_SQRT: if (r_iter == 6'(SQRT_STEPS - 1)) n_state = S_CHK;
            S_CHK: begin
                if (!r_pv || rej_ht || rej_near) n_state = S_OUT;
                else if (at_origin)              n_state = S_WIN;
                else                             n_state = S_CORD;
            end
            S_CORD: if (r_iter == 6'(CORDIC_STEPS - 1)) n_state = S_WIN;
            S_WIN:  n_state = rej_ang ? S_OUT : S_IDX;
            S_IDX:  if (r_iter == 6'(DIV_STEPS - 1)) n_state = S_BIN;
            S_BIN:  n_state = idx_in ? S_MRD : S_OUT;
            S_MRD:  n_state = S_WB;
            S_WB:   n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iter     <= '0;
            r_ov       <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= (n_state != r_state) ? 6'd0 : r_iter + 6'd1;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(MAX_BINS - 1)) r_clr_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_op      <= i_pt.operation;
                    r_px      <= i_pt.pos_x;
                    r_py      <= i_pt.pos_y;
                    r_pz      <= i_pt.pos_z;
                    r_pv      <= i_pt.point_valid;
                    r_rb      <= i_pt.read_bin;
                    r_st      <= ST_STORED;
                    r_bidx    <= '0;
                    r_brng    <= '0;
                    r_bemp    <= 1'b0;
                    r_wpos    <= win_w > 20'sd0;
                    r_div_quo <= cnt_dvd;
                    r_div_rem <= '0;
                end
            end
            S_CNT, S_IDX: begin
                r_div_rem <= div_rem_nx;
                r_div_quo <= {r_div_quo[18:0], div_ge};
            end
            S_DISP: begin
                r_count   <= cnt_val;
                r_addr    <= AW'(r_rb);
                r_sq_root <= '0;
                r_sq_bit  <= 32'd1 << 30;
                if (r_op == OP_READ) begin
                    r_bidx <= r_rb;
                    if (!rb_in) r_st <= ST_BEYOND;
                end
            end
            S_SQ: begin
                if (r_iter == 6'd0) r_sq_val <= 32'(mul_p);
                else                r_sq_val <= r_sq_val + 32'(mul_p);
            end
            S_SQRT: begin
                if (sq_ge) begin
                    r_sq_val  <= r_sq_val - sq_sum;
                    r_sq_root <= (r_sq_root >> 1) + r_sq_bit;
                    if (r_iter == 6'(SQRT_STEPS - 1)) r_range <= 16'((r_sq_root >> 1) + r_sq_bit);
                end else begin
                    r_sq_root <= r_sq_root >> 1;
                    if (r_iter == 6'(SQRT_STEPS - 1)) r_range <= 16'(r_sq_root >> 1);
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            S_CHK: begin
                if (!r_pv)         r_st <= ST_INVALID;
                else if (rej_ht)   r_st <= ST_HEIGHT;
                else if (rej_near) r_st <= ST_NEAR;
                // quarter turn into the right half plane
                if (r_px < 16'sd0) begin
                    if (r_py >= 16'sd0) begin
                        r_cx <= XW'(r_py) <<< 30;
                        r_cy <= -(XW'(r_px) <<< 30);
                        r_cz <= ATAN_TAB[0] <<< 1;
                    end else begin
                        r_cx <= -(XW'(r_py) <<< 30);
                        r_cy <= XW'(r_px) <<< 30;
                        r_cz <= -(ATAN_TAB[0] <<< 1);
                    end
                end else begin
                    r_cx <= XW'(r_px) <<< 30;
                    r_cy <= XW'(r_py) <<< 30;
                    r_cz <= '0;
                end
                if (at_origin) r_cz <= '0;
            end
            S_CORD: begin
                if (c_pos) begin
                    r_cx <= r_cx + cy_sh;
                    r_cy <= r_cy - cx_sh;
                    r_cz <= r_cz + atan_i;
                end else begin
                    r_cx <= r_cx - cy_sh;
                    r_cy <= r_cy + cx_sh;
                    r_cz <= r_cz - atan_i;
                end
            end
            S_WIN: begin
                if (rej_ang) r_st <= ST_ANGLE;
                r_div_quo <= 20'(ang_ofs);
                r_div_rem <= '0;
            end
            S_BIN: begin
                r_brng <= r_range;
                r_addr <= AW'(idx_adj);
                if (idx_in) r_bidx <= 9'(idx_adj);
                else        r_st   <= ST_BEYOND;
            end
            S_WB: begin
                if (r_op == OP_READ) begin
                    r_bemp <= mem_rdata == EMPTY_MARK;
                    r_brng <= (mem_rdata == EMPTY_MARK) ? fill_val : mem_rdata;
                end else if (r_range >= mem_rdata) begin
                    r_st <= ST_FARTHER;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_st  <= r_st;
                    r_o_idx <= r_bidx;
                    r_o_rng <= r_brng;
                    r_o_emp <= r_bemp;
                    r_o_tot <= (20'(r_count) > 20'd1023) ? 10'd1023 : 10'(r_count);
                end
            end
            default: ;
        endcase
    end

    // bin memory: clearing pass, then read-modify-write per item
    always_comb begin
        mem_re    = r_state == S_MRD;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = EMPTY_MARK;
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
        end else if (r_state == S_WB) begin
            if (r_op == OP_READ) begin
                mem_we = 1'b1;
            end else if (r_range < mem_rdata) begin
                mem_we    = 1'b1;
                mem_wdata = r_range;
            end
        end
    end

    pcsb_ram #(
        .WIDTH (16),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign o_res.valid     = r_ov;
    assign o_res.status    = r_o_st;
    assign o_res.bin_index = r_o_idx;
    assign o_res.bin_range = r_o_rng;
    assign o_res.bin_empty = r_o_emp;
    assign o_res.bin_total = r_o_tot;

    // no point may be taken while bins are being cleared
    `PCSB_ASSERT_IMP(a_no_take_in_clear, r_clr_busy, !i_pt.ready, "item taken during clear")
    // a taken item leaves idle at once
    `PCSB_ASSERT_NXT(a_take_leaves_idle, in_take, r_state != S_IDLE, "accept did not start work")
    // bin memory written only by the clear pass or write-back
    `PCSB_ASSERT_IMP(a_we_source, mem_we, r_clr_busy || r_state == S_WB, "stray bin write")
    // a result loaded into the free output register is presented as valid
    `PCSB_ASSERT_NXT(a_out_load, r_state == S_OUT && out_free, r_ov, "result not presented")

endmodule
